/* hw/rtl/gyq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyq_pkg
// Shared widths, constants, control types and the CORDIC arctangent table for
// the gyro yaw integrator.
// ----------------------------------------------------------------------------
package gyq_pkg;

   localparam int TS_BITS        = 32;
   localparam int RATE_BITS      = 16;
   localparam int DT_BITS        = 24;
   localparam int SCALE_BITS     = 24;
   localparam int ANGLE_BITS     = 32;
   localparam int PROD_SHIFT     = 16;
   localparam int PROD_BITS      = ANGLE_BITS + PROD_SHIFT;
   localparam int YAW_BITS       = 16;
   localparam int QZ_BITS        = 16;
   localparam int QW_BITS        = 15;
   localparam int VEC_BITS       = 32;
   localparam int VEC_FRAC       = 30;
   localparam int QUAT_FRAC_BITS = 14;
   localparam int RND_SHIFT      = VEC_FRAC - QUAT_FRAC_BITS;
   localparam int CORDIC_STEPS   = 16;
   localparam int CNT_BITS       = 5;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [DT_BITS-1:0]         DT_MAX      = {DT_BITS{1'b1}};
   localparam logic signed [VEC_BITS-1:0] CORDIC_GAIN = 32'sd652032875;
   localparam logic signed [VEC_BITS:0]   RND_HALF    = 33'sd1 <<< (RND_SHIFT - 1);
   localparam logic signed [VEC_BITS:0]   QUAT_ONE    = 33'sd1 <<< QUAT_FRAC_BITS;

   // register index, taken from paddr[2]
   localparam logic REG_RATE_SCALE = 1'b0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_SCALE,
      S_MUL_RATE,
      S_ACCUM,
      S_LOAD,
      S_ROTATE,
      S_EMIT
   } gyq_state_type;

   typedef struct packed {
      logic load;
      logic step_scale;
      logic step_rate;
      logic first;
   } gyq_mul_ctrl_type;

   typedef struct packed {
      logic                load;
      logic                step;
      logic [CNT_BITS-1:0] idx;
   } gyq_rot_ctrl_type;

   // atan(2^-i) in 2^-32 turn units
   function automatic logic signed [VEC_BITS-1:0] gyq_atan(input logic [CNT_BITS-1:0] idx);
      logic signed [VEC_BITS-1:0] a;
      case (idx)
         5'd0:    a = 32'sd536870912;
         5'd1:    a = 32'sd316933406;
         5'd2:    a = 32'sd167458907;
         5'd3:    a = 32'sd85004756;
         5'd4:    a = 32'sd42667331;
         5'd5:    a = 32'sd21354465;
         5'd6:    a = 32'sd10679838;
         5'd7:    a = 32'sd5340245;
         5'd8:    a = 32'sd2670163;
         5'd9:    a = 32'sd1335087;
         5'd10:   a = 32'sd667544;
         5'd11:   a = 32'sd333772;
         5'd12:   a = 32'sd166886;
         5'd13:   a = 32'sd83443;
         5'd14:   a = 32'sd41722;
         5'd15:   a = 32'sd20861;
         5'd16:   a = 32'sd10430;
         5'd17:   a = 32'sd5215;
         5'd18:   a = 32'sd2608;
         5'd19:   a = 32'sd1304;
         5'd20:   a = 32'sd652;
         5'd21:   a = 32'sd326;
         5'd22:   a = 32'sd163;
         5'd23:   a = 32'sd81;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

/* hw/rtl/gyq_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyq_csr
// Register port holding the rate scale factor.
// ----------------------------------------------------------------------------
module gyq_csr import gyq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output logic [SCALE_BITS-1:0]    rate_scale
);

   logic [SCALE_BITS-1:0] scale_ff;
   logic [SCALE_BITS-1:0] scale_in;
   logic                  wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == REG_RATE_SCALE);

   always_comb begin
      scale_in = scale_ff;
      if (wr_hit) begin
         scale_in = csr_pwdata[SCALE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
      end else begin
         scale_ff <= scale_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_RATE_SCALE) begin
         csr_prdata = {{(CSR_DATA_BITS-SCALE_BITS){1'b0}}, scale_ff};
      end
   end

   assign rate_scale = scale_ff;

endmodule

/* hw/rtl/gyq_smul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyq_smul
// Bit-serial multiplier: dt * scale one dt bit per cycle, then times the
// signed rate one rate bit per cycle, msb first, modulo 2^PROD_BITS.
// ----------------------------------------------------------------------------
module gyq_smul import gyq_pkg::*; (
   input  logic                         clock,
   input  gyq_mul_ctrl_type             ctrl,
   input  logic [DT_BITS-1:0]           dt,
   input  logic signed [RATE_BITS-1:0]  rate,
   input  logic [SCALE_BITS-1:0]        scale,
   output logic [ANGLE_BITS-1:0]        increment
);

   logic [DT_BITS-1:0]   dt_sh_ff,   dt_sh_in;
   logic [RATE_BITS-1:0] rate_sh_ff, rate_sh_in;
   logic [PROD_BITS-1:0] m1_ff,      m1_in;
   logic [PROD_BITS-1:0] p_ff,       p_in;
   logic [PROD_BITS-1:0] addend;

   always_comb begin
      dt_sh_in   = dt_sh_ff;
      rate_sh_in = rate_sh_ff;
      m1_in      = m1_ff;
      p_in       = p_ff;
      addend     = '0;
      if (rate_sh_ff[RATE_BITS-1]) begin
         // sign bit carries negative weight
         addend = ctrl.first ? (~m1_ff + 1'b1) : m1_ff;
      end
      if (ctrl.load) begin
         dt_sh_in   = dt;
         rate_sh_in = rate;
         m1_in      = '0;
         p_in       = '0;
      end else if (ctrl.step_scale) begin
         m1_in    = {m1_ff[PROD_BITS-2:0], 1'b0}
                    + (dt_sh_ff[DT_BITS-1]
                       ? {{(PROD_BITS-SCALE_BITS){1'b0}}, scale} : '0);
         dt_sh_in = {dt_sh_ff[DT_BITS-2:0], 1'b0};
      end else if (ctrl.step_rate) begin
         p_in       = {p_ff[PROD_BITS-2:0], 1'b0} + addend;
         rate_sh_in = {rate_sh_ff[RATE_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      dt_sh_ff   <= dt_sh_in;
      rate_sh_ff <= rate_sh_in;
      m1_ff      <= m1_in;
      p_ff       <= p_in;
   end

   assign increment = p_ff[PROD_SHIFT +: ANGLE_BITS];

endmodule

/* hw/rtl/gyq_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyq_cordic
// Iterative rotation-mode CORDIC, one step per cycle, giving sin and cos of
// half the yaw angle rounded and clamped to Q1.14.
// ----------------------------------------------------------------------------
module gyq_cordic import gyq_pkg::*; (
   input  logic                        clock,
   input  gyq_rot_ctrl_type            ctrl,
   input  logic [ANGLE_BITS-1:0]       angle,
   output logic signed [QZ_BITS-1:0]   quat_z,
   output logic [QW_BITS-1:0]          quat_w
);

   logic signed [VEC_BITS-1:0] x_ff, x_in;
   logic signed [VEC_BITS-1:0] y_ff, y_in;
   logic signed [VEC_BITS-1:0] z_ff, z_in;
   logic signed [VEC_BITS-1:0] sx;
   logic signed [VEC_BITS-1:0] sy;
   logic signed [VEC_BITS-1:0] atan_val;
   logic signed [VEC_BITS:0]   y_rnd;
   logic signed [VEC_BITS:0]   x_rnd;

   assign sx       = x_ff >>> ctrl.idx;
   assign sy       = y_ff >>> ctrl.idx;
   assign atan_val = gyq_atan(ctrl.idx);

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (ctrl.load) begin
         x_in = CORDIC_GAIN;
         y_in = '0;
         // half angle, 2^-32 turn units
         z_in = {angle[ANGLE_BITS-1], angle[ANGLE_BITS-1:1]};
      end else if (ctrl.step) begin
         if (!z_ff[VEC_BITS-1]) begin
            x_in = x_ff - sy;
            y_in = y_ff + sx;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + sy;
            y_in = y_ff - sx;
            z_in = z_ff + atan_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   // round half up, then clamp
   assign y_rnd = ($signed({y_ff[VEC_BITS-1], y_ff}) + RND_HALF) >>> RND_SHIFT;
   assign x_rnd = ($signed({x_ff[VEC_BITS-1], x_ff}) + RND_HALF) >>> RND_SHIFT;

   always_comb begin
      if (y_rnd < -QUAT_ONE) begin
         quat_z = QZ_BITS'(-QUAT_ONE);
      end else if (y_rnd > QUAT_ONE) begin
         quat_z = QZ_BITS'(QUAT_ONE);
      end else begin
         quat_z = y_rnd[QZ_BITS-1:0];
      end
      if (x_rnd < 0) begin
         quat_w = '0;
      end else if (x_rnd > QUAT_ONE) begin
         quat_w = QW_BITS'(QUAT_ONE);
      end else begin
         quat_w = x_rnd[QW_BITS-1:0];
      end
   end

endmodule

/* hw/rtl/gyro_yaw_integrator_quaternion.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_yaw_integrator_quaternion
// Integrates gyro z rate over sample time into a wrapping yaw angle and
// returns the angle with its yaw quaternion (z, w) in Q1.14.
//
// channel  direction  content
// req_     in         timestamp_us, yaw_rate
// rsp_     out        yaw_angle, quat_z, quat_w
// csr_     in/out     rate_scale at byte address 0
//
// the first sample after reset returns nothing.
// every later sample runs, from acceptance to result, the bit-serial dt*scale
// product, the times-rate product, the add and the CORDIC load, 16 CORDIC
// steps and the result register; the next sample is taken only once the
// block is back in the idle state.
// req_tready is high only between samples; a held result blocks the final
// register load, and no new sample is taken while it waits.
// reset clears the yaw, the stored time, the start flag and rate_scale.
// ----------------------------------------------------------------------------
module gyro_yaw_integrator_quaternion import gyq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [47:0]              req_tdata,  // timestamp_us[31:0], yaw_rate[47:32]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [47:0]              rsp_tdata,  // yaw_angle[15:0], quat_z[31:16],
                                                // quat_w[46:32], zero[47]
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   gyq_state_type state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  started_ff, started_in;
   logic [TS_BITS-1:0]    prev_ts_ff, prev_ts_in;
   logic [ANGLE_BITS-1:0] acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [YAW_BITS-1:0]   yaw_ff, yaw_in;
   logic [QZ_BITS-1:0]    qz_ff, qz_in;
   logic [QW_BITS-1:0]    qw_ff, qw_in;

   logic [TS_BITS-1:0]          ts;
   logic signed [RATE_BITS-1:0] rate;
   logic [TS_BITS-1:0]          ts_diff;
   logic [DT_BITS-1:0]          dt;
   logic [SCALE_BITS-1:0]       rate_scale;
   logic [ANGLE_BITS-1:0]       increment;
   logic signed [QZ_BITS-1:0]   quat_z;
   logic [QW_BITS-1:0]          quat_w;
   logic                        req_fire;
   logic                        out_free;
   logic                        acc_en;
   logic                        out_load;
   gyq_mul_ctrl_type            mul_ctrl;
   gyq_rot_ctrl_type            rot_ctrl;

   assign ts       = req_tdata[TS_BITS-1:0];
   assign rate     = req_tdata[TS_BITS +: RATE_BITS];
   assign ts_diff  = ts - prev_ts_ff;
   assign dt       = (|ts_diff[TS_BITS-1:DT_BITS]) ? DT_MAX : ts_diff[DT_BITS-1:0];
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   gyq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .rate_scale  (rate_scale)
   );

   gyq_smul u_smul (
      .clock     (clock),
      .ctrl      (mul_ctrl),
      .dt        (dt),
      .rate      (rate),
      .scale     (rate_scale),
      .increment (increment)
   );

   gyq_cordic u_cordic (
      .clock  (clock),
      .ctrl   (rot_ctrl),
      .angle  (acc_ff),
      .quat_z (quat_z),
      .quat_w (quat_w)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && started_ff) begin
               state_in = S_MUL_SCALE;
            end
         end
         S_MUL_SCALE: begin
            if (cnt_ff == CNT_BITS'(DT_BITS - 1)) begin
               state_in = S_MUL_RATE;
            end
         end
         S_MUL_RATE: begin
            if (cnt_ff == CNT_BITS'(RATE_BITS - 1)) begin
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: state_in = S_LOAD;
         S_LOAD:  state_in = S_ROTATE;
         S_ROTATE: begin
            if (cnt_ff == CNT_BITS'(CORDIC_STEPS - 1)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready          = 1'b0;
      mul_ctrl            = '0;
      rot_ctrl            = '0;
      acc_en              = 1'b0;
      out_load            = 1'b0;
      rot_ctrl.idx        = cnt_ff;
      mul_ctrl.first      = (cnt_ff == '0);
      case (state_ff)
         S_IDLE: begin
            req_tready    = 1'b1;
            mul_ctrl.load = req_fire;
         end
         S_MUL_SCALE: mul_ctrl.step_scale = 1'b1;
         S_MUL_RATE:  mul_ctrl.step_rate  = 1'b1;
         S_ACCUM:     acc_en              = 1'b1;
         S_LOAD:      rot_ctrl.load       = 1'b1;
         S_ROTATE:    rot_ctrl.step       = 1'b1;
         S_EMIT:      out_load            = out_free;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in       = (state_in != state_ff) ? '0 : cnt_ff + 1'b1;
      started_in   = started_ff;
      prev_ts_in   = prev_ts_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      yaw_in       = yaw_ff;
      qz_in        = qz_ff;
      qw_in        = qw_ff;
      if (req_fire) begin
         started_in = 1'b1;
         prev_ts_in = ts;
      end
      if (acc_en) begin
         acc_in = acc_ff + increment;
      end
      if (rsp_tvalid && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         yaw_in       = acc_ff[ANGLE_BITS-1 -: YAW_BITS];
         qz_in        = quat_z;
         qw_in        = quat_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         started_ff   <= 1'b0;
         prev_ts_ff   <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         started_ff   <= started_in;
         prev_ts_ff   <= prev_ts_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      yaw_ff <= yaw_in;
      qz_ff  <= qz_in;
      qw_ff  <= qw_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, qw_ff, qz_ff, yaw_ff};

   // a result is only loaded at the end of a rotation
   a_load_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result loaded outside emit state");

   // the yaw only moves once per sample, after both products
   a_acc_only_in_accum: assert property (@(posedge clock) disable iff (reset)
      (acc_ff != $past(acc_ff)) |-> $past(state_ff == S_ACCUM))
      else $error("yaw accumulator changed outside accumulate step");

   // the rotation never runs past its step count
   a_rotate_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROTATE |-> cnt_ff < CNT_BITS'(CORDIC_STEPS))
      else $error("cordic step index out of range");

   // a first sample after reset never starts the multiplier
   a_first_no_work: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !started_ff) |=> state_ff == S_IDLE && started_ff)
      else $error("first sample started a computation");

   // cosine of half yaw stays within one
   a_quat_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> qw_ff <= QW_BITS'(QUAT_ONE))
      else $error("quat_w out of range");

endmodule

/* bench/tb_gyro_yaw_integrator_quaternion.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gyro_yaw_integrator_quaternion
// Self-checking bench for the gyro yaw integrator. Gyro samples go in on the
// request stream and rate_scale is set over the register port. A tracker
// keeps its own yaw, previous time and start flag, and predicts yaw_angle,
// quat_z and quat_w for every accepted sample. It then checks each returned
// transaction against the oldest prediction. Directed samples cover time
// wrap, dt saturation, rate extremes and the yaw = -pi point. Random samples
// follow under several scale settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_gyro_yaw_integrator_quaternion;
   import gyq_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] RATE_SCALE_ADDR = {REG_RATE_SCALE, 2'b00};
   localparam logic [DT_BITS-1:0]       DT_LIMIT        = 24'hFFFFFF;
   localparam int                       DRAIN_CYCLES    = 64;
   localparam int                       RANDOM_PER_SET  = 158;

   typedef struct packed {
      logic [15:0] yaw;
      logic [15:0] qz;
      logic [14:0] qw;
   } yaw_quat_type;

   class yaw_tracker;
      logic [31:0]    yaw_acc;
      logic [31:0]    last_ts;
      bit             started;
      logic [23:0]    scale;
      yaw_quat_type   expected_quats[$];
      int             errors;
      // atan(2^-i) in 2^-32 turn
      longint         atan_turn[16];

      function new();
         atan_turn = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                       10679838, 5340245, 2670163, 1335087, 667544, 333772,
                       166886, 83443, 41722, 20861};
         yaw_acc = '0;
         last_ts = '0;
         started = 0;
         scale   = '0;
         errors  = 0;
      endfunction

      function void set_scale(logic [23:0] value);
         scale = value;
      endfunction

      function int pending();
         return expected_quats.size();
      endfunction

      function yaw_quat_type rotate_half_yaw(logic [31:0] acc);
         longint       z, x, y, nx, ny, qz, qw;
         yaw_quat_type r;
         z = longint'($signed(acc)) >>> 1;
         x = 64'sd652032875;
         y = 0;
         for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               ny = y + (x >>> i);
               z  = z - atan_turn[i];
            end else begin
               nx = x + (y >>> i);
               ny = y - (x >>> i);
               z  = z + atan_turn[i];
            end
            x = nx;
            y = ny;
         end
         // round half up from Q30 to Q14, then clamp
         qz = (y + 32768) >>> 16;
         qw = (x + 32768) >>> 16;
         if (qz < -16384) qz = -16384;
         if (qz > 16384) qz = 16384;
         if (qw < 0) qw = 0;
         if (qw > 16384) qw = 16384;
         r.yaw = acc[31:16];
         r.qz  = qz[15:0];
         r.qw  = qw[14:0];
         return r;
      endfunction

      function void note_sample(logic [31:0] ts, logic signed [15:0] rate);
         logic [31:0] dt;
         longint      rate_l, dt_l, scale_l, prod;
         if (!started) begin
            last_ts = ts;
            started = 1;
            return;
         end
         dt = ts - last_ts;
         if (dt > 32'(DT_LIMIT)) dt = 32'(DT_LIMIT);
         last_ts = ts;
         rate_l  = rate;
         dt_l    = dt;
         scale_l = scale;
         prod    = (rate_l * dt_l * scale_l) >>> 16;
         yaw_acc = yaw_acc + prod[31:0];
         expected_quats.push_back(rotate_half_yaw(yaw_acc));
      endfunction

      function void check_result(logic [47:0] data);
         yaw_quat_type e;
         if (expected_quats.size() == 0) begin
            $error("result transaction with no sample pending: %h", data);
            errors++;
            return;
         end
         e = expected_quats.pop_front();
         if (data[15:0] !== e.yaw) begin
            $error("yaw_angle: expected %0d, got %0d", $signed(e.yaw), $signed(data[15:0]));
            errors++;
         end
         if (data[31:16] !== e.qz) begin
            $error("quat_z: expected %0d, got %0d", $signed(e.qz), $signed(data[31:16]));
            errors++;
         end
         if (data[46:32] !== e.qw) begin
            $error("quat_w: expected %0d, got %0d", e.qw, data[46:32]);
            errors++;
         end
         if (data[47] !== 1'b0) begin
            $error("rsp_tdata[47]: expected 0, got %b", data[47]);
            errors++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [47:0]              req_tdata;   // timestamp_us[31:0], yaw_rate[47:32]
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [47:0]              rsp_tdata;   // yaw_angle[15:0], quat_z[31:16], quat_w[46:32], zero
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   yaw_tracker  tracker = new();
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   logic [31:0] stim_ts = '0;

   gyro_yaw_integrator_quaternion DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // result side: check accepted transactions, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_result(rsp_tdata);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic write_rate_scale(logic [23:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= RATE_SCALE_ADDR;
      csr_pwdata  <= {8'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.set_scale(value);
   endtask

   task automatic send_sample(logic [31:0] ts, logic signed [15:0] rate);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rate, ts};
      do @(posedge clock); while (!req_tready);
      tracker.note_sample(ts, rate);
      stim_ts = ts;
   endtask

   task automatic send_random_sample();
      logic [31:0]        ts;
      logic signed [15:0] rate;
      int                 pick;
      pick = $urandom_range(99);
      if (pick < 60)      ts = stim_ts + $urandom_range(1, 20000);
      else if (pick < 75) ts = stim_ts + $urandom_range(0, 32'(DT_LIMIT));
      else if (pick < 80) ts = stim_ts;
      else if (pick < 85) ts = stim_ts + $urandom_range(32'hFFFFFE, 32'h1000001);
      else if (pick < 93) ts = stim_ts + $urandom();
      else                ts = $urandom();
      case ($urandom_range(19))
         0:       rate = -16'sd32768;
         1:       rate = 16'sd32767;
         2:       rate = -16'sd1;
         3:       rate = 16'sd0;
         default: rate = 16'($urandom());
      endcase
      send_sample(ts, rate);
   endtask

   // let the block go idle before touching the register
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      rsp_tready  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unit scale: increment is rate * dt
      write_rate_scale(24'd65536);
      send_sample(32'hFFFF_0000, 16'sd123);      // first sample only latches time
      send_sample(32'h0000_0000, -16'sd32768);   // time wraps, yaw lands on -pi
      send_sample(32'h0001_0000, 16'sd32767);
      send_sample(32'h0101_0000, 16'sd1);        // dt of 2^24 saturates
      send_sample(32'h8101_0000, -16'sd1);       // long gap
      send_sample(32'h8101_0000, 16'sd32767);    // zero dt
      send_sample(32'h8200_FFFF, -16'sd32768);   // dt right at the limit
      send_sample(32'h8200_FFFE, 16'sd0);        // dt wraps to all ones
      send_sample(32'h8200_FFFF, -16'sd1);
      send_sample(32'hFFFF_FFFF, 16'sd32767);
      drain();

      write_rate_scale(DT_LIMIT);
      send_sample(stim_ts + 32'(DT_LIMIT), -16'sd32768);
      send_sample(stim_ts + 32'(DT_LIMIT), 16'sd32767);
      send_sample(stim_ts + 32'd1, -16'sd1);
      send_sample(stim_ts + 32'd12345, 16'sd1);
      drain();

      write_rate_scale(24'd0);
      send_sample(stim_ts + 32'd1000, -16'sd32768);
      send_sample(stim_ts + 32'(DT_LIMIT), 16'sd32767);
      drain();

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               tx_idle_pct = 33;
               rx_idle_pct = 74;
            end
            1: begin
               tx_idle_pct = 74;
               rx_idle_pct = 33;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         for (int set = 0; set < 2; set++) begin
            case (mode * 2 + set)
               0:       write_rate_scale(24'($urandom()));
               1:       write_rate_scale(24'd65536);
               2:       write_rate_scale(24'($urandom_range(1, 255)));
               3:       write_rate_scale(DT_LIMIT);
               4:       write_rate_scale(24'($urandom_range(256, 65535)));
               default: write_rate_scale(24'($urandom()));
            endcase
            repeat (RANDOM_PER_SET) send_random_sample();
            drain();
         end
      end

      if (tracker.errors == 0) begin
         $display("gyro_yaw_integrator_quaternion regression: pass");
      end else begin
         $display("gyro_yaw_integrator_quaternion regression: fail");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("gyro_yaw_integrator_quaternion regression: fail");
      $finish;
   end

endmodule
